// File: design/mhtu_pkg.sv
// Package: shared constants, register indexes and result word type for the housekeeping timer.
`default_nettype none
package mhtu_pkg;

    // Debounce pattern bits
    localparam logic [15:0] PatternForce = 16'he000;
    localparam logic [15:0] PatternPress = 16'hf000;

    // Time base
    localparam int unsigned TicksPerSec = 1000;
    localparam int unsigned SecsPerMin  = 60;

    // Saturation and receive gap limits
    localparam logic [15:0] Sat16    = 16'hffff;
    localparam logic [7:0]  Sat8     = 8'hff;
    localparam logic [7:0]  RxGapMin = 8'd10;

    // Reset values that are not zero
    localparam logic [15:0] LoadOffReset = 16'd2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_WD_LIMIT   = 2'd0,
        CFG_LOAD_OFF   = 2'd1,
        CFG_ADC_PERIOD = 2'd2
    } t_cfg_index;

    // One result word
    typedef struct packed {
        logic        button_pressed;
        logic        led_on;
        logic        load_power_enable;
        logic        adc_sample_strobe;
        logic        rx_parse_strobe;
        logic [15:0] run_minutes;
        logic [15:0] interval_ms;
        logic [15:0] wd_elapsed;
    } t_result;

endpackage
`default_nettype wire

// File: design/millisecond_housekeeping_timer_unit.sv
// Top level: millisecond tick housekeeping timer with output register and skid stage.
// Result words are registered in the output register, or the skid stage on a stall.
// Throughput: one tick word per cycle, if not stalled; all counters update in one
// pass of short increment and compare logic between the state and result registers.
// Reset (synchronous, active low) restores every counter to its power-up value
// and clears the config registers; no clearing pass is needed.
`default_nettype none
module millisecond_housekeeping_timer_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // tick input channel
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic                      i_button_pin,
    input  wire logic                      i_adc_count_clear,
    input  wire logic                      i_rx_data_pending,
    input  wire logic                      i_rx_gap_clear,
    input  wire logic [7:0]                i_led_load_ms,
    input  wire logic                      i_watchdog_clear,
    input  wire logic                      i_interval_clear,
    input  wire logic [15:0]               i_force_off_seconds,
    // result output channel
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_button_pressed,
    output logic                           o_led_on,
    output logic                           o_load_power_enable,
    output logic                           o_adc_sample_strobe,
    output logic                           o_rx_parse_strobe,
    output logic [15:0]                    o_run_minutes,
    output logic [15:0]                    o_interval_ms,
    output logic [15:0]                    o_wd_elapsed,
    // config write port
    input  wire logic                      i_cfg_we,
    input  wire mhtu_pkg::t_cfg_index      i_cfg_index,
    input  wire logic [15:0]               i_cfg_data
);
    import mhtu_pkg::*;

    // config registers
    logic [15:0] r_wd_limit, r_load_off_time, r_adc_period;

    // timer state
    logic        r_last_pin, n_last_pin;
    logic [15:0] r_shift, n_shift;
    logic [7:0]  r_led, n_led;
    logic [15:0] r_interval, n_interval;
    logic [9:0]  r_tick, n_tick;
    logic [5:0]  r_second, n_second;
    logic [15:0] r_uptime, n_uptime;
    logic [15:0] r_wd, n_wd;
    logic [15:0] r_load_off, n_load_off;
    logic        r_pwr, n_pwr;
    logic [15:0] r_adc, n_adc;
    logic [7:0]  r_gap, n_gap;

    // output register and skid stage
    t_result     r_out, r_skid, n_result;
    logic        r_out_valid, r_skid_valid;

    logic        acc, take, sec_edge;

    // handshake
    assign acc     = i_valid && !r_skid_valid;
    assign take    = r_out_valid && !i_stall;
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;

    assign o_button_pressed    = r_out.button_pressed;
    assign o_led_on            = r_out.led_on;
    assign o_load_power_enable = r_out.load_power_enable;
    assign o_adc_sample_strobe = r_out.adc_sample_strobe;
    assign o_rx_parse_strobe   = r_out.rx_parse_strobe;
    assign o_run_minutes       = r_out.run_minutes;
    assign o_interval_ms       = r_out.interval_ms;
    assign o_wd_elapsed        = r_out.wd_elapsed;

    assign sec_edge = (r_tick == 10'(TicksPerSec - 1));

    // next state and result for one tick
    always_comb begin
        logic [15:0] wd, lor;
        logic [7:0]  led, gap;
        logic [15:0] ic, adc;
        logic        led_now, strobe;

        // loads and clears from the tick word
        led = (i_led_load_ms != 8'd0) ? i_led_load_ms : r_led;
        wd  = i_watchdog_clear ? 16'd0 : r_wd;
        ic  = i_interval_clear ? 16'd0 : r_interval;
        lor = (i_force_off_seconds != 16'd0) ? i_force_off_seconds : r_load_off;
        adc = i_adc_count_clear ? 16'd0 : r_adc;
        gap = i_rx_gap_clear ? 8'd0 : r_gap;

        // debounce on the previous sample
        n_shift    = {r_shift[14:0], ~r_last_pin} | PatternForce;
        n_last_pin = i_button_pin;

        // LED countdown
        led_now = (led != 8'd0);
        n_led   = led_now ? led - 8'd1 : led;

        // interval counter
        n_interval = (ic != Sat16) ? ic + 16'd1 : ic;

        // second and minute base, watchdog and load power
        n_pwr    = r_pwr;
        n_second = r_second;
        n_uptime = r_uptime;
        if (sec_edge) begin
            n_tick = 10'd0;
            if (wd != Sat16) begin
                wd = wd + 16'd1;
            end
            if (r_wd_limit != 16'd0 && wd > r_wd_limit && lor == 16'd0) begin
                lor = r_load_off_time;
            end
            if (lor == 16'd0) begin
                n_pwr = 1'b1;
            end else begin
                n_pwr = 1'b0;
                lor   = lor - 16'd1;
                if (lor == 16'd0) begin
                    wd = 16'd0;
                end
            end
            if (r_second == 6'(SecsPerMin - 1)) begin
                n_second = 6'd0;
                if (r_uptime != Sat16) begin
                    n_uptime = r_uptime + 16'd1;
                end
            end else begin
                n_second = r_second + 6'd1;
            end
        end else begin
            n_tick = r_tick + 10'd1;
        end
        n_wd       = wd;
        n_load_off = lor;

        // ADC strobe, 16-bit wrap
        adc    = adc + 16'd1;
        strobe = (adc == r_adc_period);
        n_adc  = strobe ? 16'd0 : adc;

        // receive gap
        n_gap = (gap != Sat8) ? gap + 8'd1 : gap;

        n_result.button_pressed    = (n_shift == PatternPress);
        n_result.led_on            = led_now;
        n_result.load_power_enable = n_pwr;
        n_result.adc_sample_strobe = strobe;
        n_result.rx_parse_strobe   = (n_gap >= RxGapMin) && i_rx_data_pending;
        n_result.run_minutes       = n_uptime;
        n_result.interval_ms       = n_interval;
        n_result.wd_elapsed        = n_wd;
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd_limit      <= 16'd0;
            r_load_off_time <= 16'd0;
            r_adc_period    <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WD_LIMIT:   r_wd_limit      <= i_cfg_data;
                CFG_LOAD_OFF:   r_load_off_time <= i_cfg_data;
                CFG_ADC_PERIOD: r_adc_period    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // timer state, advanced once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pin <= 1'b1;
            r_shift    <= 16'd0;
            r_led      <= 8'd0;
            r_interval <= 16'd0;
            r_tick     <= 10'd0;
            r_second   <= 6'd0;
            r_uptime   <= 16'd0;
            r_wd       <= 16'd0;
            r_load_off <= LoadOffReset;
            r_pwr      <= 1'b0;
            r_adc      <= 16'd0;
            r_gap      <= Sat8;
        end else if (acc) begin
            r_last_pin <= n_last_pin;
            r_shift    <= n_shift;
            r_led      <= n_led;
            r_interval <= n_interval;
            r_tick     <= n_tick;
            r_second   <= n_second;
            r_uptime   <= n_uptime;
            r_wd       <= n_wd;
            r_load_off <= n_load_off;
            r_pwr      <= n_pwr;
            r_adc      <= n_adc;
            r_gap      <= n_gap;
        end
    end

    // output register and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take || !r_out_valid) begin
                r_out_valid  <= r_skid_valid || acc;
                r_skid_valid <= 1'b0;
            end else if (acc) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (acc && r_out_valid && !take) begin
            r_skid <= n_result;
        end
    end

    // checks
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < 10'(TicksPerSec))
        else $error("tick counter out of range");

    a_second_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second < 6'(SecsPerMin))
        else $error("second counter out of range");

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_accept_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted tick produced no result word");

    a_power_on_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (n_pwr != r_pwr)) |-> sec_edge)
        else $error("load power changed off a second boundary");

endmodule
`default_nettype wire

// File: tb/mhtu_tick_checker.sv
`timescale 1ns / 100ps
// Checker: predicts each result word of the housekeeping timer and compares.
module mhtu_tick_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // tick channel as seen at the unit input
    input  wire logic                 i_tick_valid,
    input  wire logic                 i_tick_stall,
    input  wire logic                 i_button_pin,
    input  wire logic                 i_adc_count_clear,
    input  wire logic                 i_rx_data_pending,
    input  wire logic                 i_rx_gap_clear,
    input  wire logic [7:0]           i_led_load_ms,
    input  wire logic                 i_watchdog_clear,
    input  wire logic                 i_interval_clear,
    input  wire logic [15:0]          i_force_off_seconds,
    // result channel
    input  wire logic                 i_res_valid,
    input  wire logic                 i_res_stall,
    input  wire logic                 i_button_pressed,
    input  wire logic                 i_led_on,
    input  wire logic                 i_load_power_enable,
    input  wire logic                 i_adc_sample_strobe,
    input  wire logic                 i_rx_parse_strobe,
    input  wire logic [15:0]          i_run_minutes,
    input  wire logic [15:0]          i_interval_ms,
    input  wire logic [15:0]          i_wd_elapsed,
    // config writes
    input  wire logic                 i_cfg_we,
    input  wire mhtu_pkg::t_cfg_index i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    // status to the top
    output int                        o_fail_count,
    output int                        o_outstanding
);
    import mhtu_pkg::*;

    typedef struct packed {
        logic        pin;
        logic        adc_clr;
        logic        pending;
        logic        gap_clr;
        logic [7:0]  led_load;
        logic        wd_clr;
        logic        ival_clr;
        logic [15:0] force_off;
    } t_tick;

    // shadow copy of the unit's counters and config
    logic        pin_prev;
    logic [15:0] bounce_bits;
    logic [7:0]  led_left;
    logic [15:0] ival_count;
    logic [9:0]  ms_in_sec;
    logic [5:0]  sec_in_min;
    logic [15:0] minutes;
    logic [15:0] wd_secs;
    logic [15:0] off_left;
    logic        power_on;
    logic [15:0] adc_ticks;
    logic [7:0]  gap_ticks;
    logic [15:0] wd_limit;
    logic [15:0] off_time;
    logic [15:0] adc_period;

    t_result expected_words[$];
    int      fail_count = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    // one millisecond tick: loads and clears first, then every counter advances
    function t_result advance_ms(input t_tick tk);
        t_result r;
        if (tk.led_load != 8'd0) led_left = tk.led_load;
        if (tk.wd_clr) wd_secs = 16'd0;
        if (tk.ival_clr) ival_count = 16'd0;
        if (tk.force_off != 16'd0) off_left = tk.force_off;
        if (tk.adc_clr) adc_ticks = 16'd0;
        if (tk.gap_clr) gap_ticks = 8'd0;

        // debounce works on the sample stored last tick
        bounce_bits = {bounce_bits[14:0], ~pin_prev} | PatternForce;
        r.button_pressed = (bounce_bits == PatternPress);
        pin_prev = tk.pin;

        r.led_on = (led_left != 8'd0);
        if (led_left != 8'd0) led_left = led_left - 8'd1;

        if (ival_count != Sat16) ival_count = ival_count + 16'd1;

        // second boundary: watchdog, load power, minute divider
        if (ms_in_sec == 10'(TicksPerSec - 1)) begin
            ms_in_sec = 10'd0;
            if (wd_secs != Sat16) wd_secs = wd_secs + 16'd1;
            if (wd_limit != 16'd0 && wd_secs > wd_limit && off_left == 16'd0)
                off_left = off_time;
            if (off_left == 16'd0) begin
                power_on = 1'b1;
            end else begin
                power_on = 1'b0;
                off_left = off_left - 16'd1;
                if (off_left == 16'd0) wd_secs = 16'd0;
            end
            if (sec_in_min == 6'(SecsPerMin - 1)) begin
                sec_in_min = 6'd0;
                if (minutes != Sat16) minutes = minutes + 16'd1;
            end else begin
                sec_in_min = sec_in_min + 6'd1;
            end
        end else begin
            ms_in_sec = ms_in_sec + 10'd1;
        end

        // ADC strobe, period zero falls out of the 16-bit wrap
        adc_ticks = adc_ticks + 16'd1;
        r.adc_sample_strobe = (adc_ticks == adc_period);
        if (r.adc_sample_strobe) adc_ticks = 16'd0;

        if (gap_ticks != Sat8) gap_ticks = gap_ticks + 8'd1;
        r.rx_parse_strobe = (gap_ticks >= RxGapMin) && tk.pending;

        r.load_power_enable = power_on;
        r.run_minutes       = minutes;
        r.interval_ms       = ival_count;
        r.wd_elapsed        = wd_secs;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, fname, want, got);
            fail_count++;
        end
    endtask

    // watch both channels and the config port
    always @(posedge i_clk) begin
        t_result want;
        t_tick   tk;
        if (!i_rst_n) begin
            pin_prev    = 1'b1;
            bounce_bits = 16'd0;
            led_left    = 8'd0;
            ival_count  = 16'd0;
            ms_in_sec   = 10'd0;
            sec_in_min  = 6'd0;
            minutes     = 16'd0;
            wd_secs     = 16'd0;
            off_left    = LoadOffReset;
            power_on    = 1'b0;
            adc_ticks   = 16'd0;
            gap_ticks   = Sat8;
            wd_limit    = 16'd0;
            off_time    = 16'd0;
            adc_period  = 16'd0;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WD_LIMIT:   wd_limit = i_cfg_data;
                    CFG_LOAD_OFF:   off_time = i_cfg_data;
                    CFG_ADC_PERIOD: adc_period = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: result word with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("button_pressed", want.button_pressed, i_button_pressed);
                    check_field("led_on", want.led_on, i_led_on);
                    check_field("load_power_enable", want.load_power_enable,
                                i_load_power_enable);
                    check_field("adc_sample_strobe", want.adc_sample_strobe,
                                i_adc_sample_strobe);
                    check_field("rx_parse_strobe", want.rx_parse_strobe, i_rx_parse_strobe);
                    check_field("run_minutes", want.run_minutes, i_run_minutes);
                    check_field("interval_ms", want.interval_ms, i_interval_ms);
                    check_field("wd_elapsed", want.wd_elapsed, i_wd_elapsed);
                end
            end
            if (i_tick_valid && !i_tick_stall) begin
                tk.pin       = i_button_pin;
                tk.adc_clr   = i_adc_count_clear;
                tk.pending   = i_rx_data_pending;
                tk.gap_clr   = i_rx_gap_clear;
                tk.led_load  = i_led_load_ms;
                tk.wd_clr    = i_watchdog_clear;
                tk.ival_clr  = i_interval_clear;
                tk.force_off = i_force_off_seconds;
                expected_words.push_back(advance_ms(tk));
            end
        end
        outstanding <= expected_words.size();
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives tick words and config writes into the timer, gives the verdict.
module tb_top;
    import mhtu_pkg::*;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        tick_valid  = 1'b0;
    logic        btn_pin     = 1'b1;
    logic        adc_clr     = 1'b0;
    logic        rx_pending  = 1'b0;
    logic        gap_clr     = 1'b0;
    logic [7:0]  led_load    = 8'd0;
    logic        wd_clr      = 1'b0;
    logic        ival_clr    = 1'b0;
    logic [15:0] force_off   = 16'd0;
    logic        res_stall   = 1'b0;
    logic        cfg_we      = 1'b0;
    t_cfg_index  cfg_index   = CFG_WD_LIMIT;
    logic [15:0] cfg_data    = 16'd0;

    logic        tick_stall;
    logic        res_valid;
    logic        button_pressed;
    logic        led_on;
    logic        load_power_enable;
    logic        adc_sample_strobe;
    logic        rx_parse_strobe;
    logic [15:0] run_minutes;
    logic [15:0] interval_ms;
    logic [15:0] wd_elapsed;

    int          fail_count;
    int          outstanding;

    // sender pacing and button run state
    int          burst_left = 0;
    logic        pin_level  = 1'b1;
    int          pin_run    = 0;

    millisecond_housekeeping_timer_unit uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (tick_valid),
        .o_stall             (tick_stall),
        .i_button_pin        (btn_pin),
        .i_adc_count_clear   (adc_clr),
        .i_rx_data_pending   (rx_pending),
        .i_rx_gap_clear      (gap_clr),
        .i_led_load_ms       (led_load),
        .i_watchdog_clear    (wd_clr),
        .i_interval_clear    (ival_clr),
        .i_force_off_seconds (force_off),
        .o_valid             (res_valid),
        .i_stall             (res_stall),
        .o_button_pressed    (button_pressed),
        .o_led_on            (led_on),
        .o_load_power_enable (load_power_enable),
        .o_adc_sample_strobe (adc_sample_strobe),
        .o_rx_parse_strobe   (rx_parse_strobe),
        .o_run_minutes       (run_minutes),
        .o_interval_ms       (interval_ms),
        .o_wd_elapsed        (wd_elapsed),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    mhtu_tick_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_tick_valid        (tick_valid),
        .i_tick_stall        (tick_stall),
        .i_button_pin        (btn_pin),
        .i_adc_count_clear   (adc_clr),
        .i_rx_data_pending   (rx_pending),
        .i_rx_gap_clear      (gap_clr),
        .i_led_load_ms       (led_load),
        .i_watchdog_clear    (wd_clr),
        .i_interval_clear    (ival_clr),
        .i_force_off_seconds (force_off),
        .i_res_valid         (res_valid),
        .i_res_stall         (res_stall),
        .i_button_pressed    (button_pressed),
        .i_led_on            (led_on),
        .i_load_power_enable (load_power_enable),
        .i_adc_sample_strobe (adc_sample_strobe),
        .i_rx_parse_strobe   (rx_parse_strobe),
        .i_run_minutes       (run_minutes),
        .i_interval_ms       (interval_ms),
        .i_wd_elapsed        (wd_elapsed),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_outstanding       (outstanding)
    );

    // 50 MHz clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // offer one tick word and hold it until the unit takes it
    task automatic send_tick(input logic pin, input logic a_clr, input logic pend,
                             input logic g_clr, input logic [7:0] led, input logic w_clr,
                             input logic i_clr, input logic [15:0] off);
        btn_pin    <= pin;
        adc_clr    <= a_clr;
        rx_pending <= pend;
        gap_clr    <= g_clr;
        led_load   <= led;
        wd_clr     <= w_clr;
        ival_clr   <= i_clr;
        force_off  <= off;
        tick_valid <= 1'b1;
        do @(posedge clk); while (tick_stall);
    endtask

    // bursts of words with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // button held in runs so that full debounce presses occur, with short bounces too
    task automatic send_random_tick(input int gap_pct);
        logic [7:0]  led;
        logic [15:0] off;
        if (pin_run == 0) begin
            pin_level = ~pin_level;
            pin_run   = $urandom_range(1, 20);
        end
        pin_run--;
        led = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        off = 16'd0;
        if ($urandom_range(0, 99) == 0)
            off = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                              : 16'($urandom_range(1, 3));
        send_tick(pin_level, $urandom_range(0, 49) == 0, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 99) < gap_pct, led, $urandom_range(0, 99) == 0,
                  $urandom_range(0, 99) == 0, off);
        pace();
    endtask

    task automatic run_phase(input int count, input int gap_pct);
        for (int n = 0; n < count; n++)
            send_random_tick(gap_pct);
    endtask

    // stop offering, let every expected word come out, then settle
    task automatic drain();
        tick_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_config(input logic [15:0] wd, input logic [15:0] off,
                                input logic [15:0] adc);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WD_LIMIT;
        cfg_data  <= wd;
        @(posedge clk);
        cfg_index <= CFG_LOAD_OFF;
        cfg_data  <= off;
        @(posedge clk);
        cfg_index <= CFG_ADC_PERIOD;
        cfg_data  <= adc;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: stall pattern by segments, with a long hold-off now and then
    initial begin
        int seg;
        int len;
        int pct;
        seg = 0;
        forever begin
            seg++;
            if (seg % 8 == 3) begin
                len = $urandom_range(40, 90);
                pct = 100;
            end else begin
                len = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 50;
                    default: pct = 80;
                endcase
            end
            repeat (len) begin
                @(posedge clk);
                res_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // main sequence
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, smallest loads, a clean press, gap and strobe cases
        send_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
        pace();
        send_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'hff, 1'b1, 1'b1, 16'hffff);
        pace();
        send_tick(1'b1, 1'b0, 1'b1, 1'b0, 8'd1, 1'b0, 1'b0, 16'd1);
        pace();
        // fourteen pressed samples; the press fires only after twelve released samples follow them
        for (int n = 0; n < 14; n++) begin
            send_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
            pace();
        end
        send_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0, 1'b0, 16'd0);
        pace();
        send_tick(1'b1, 1'b0, 1'b1, 1'b1, 8'd0, 1'b0, 1'b0, 16'd0);
        pace();
        send_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0, 1'b1, 16'd0);
        pace();

        // reset config: watchdog disabled, ADC every 65536 ticks
        run_phase(500, 10);
        drain();
        write_config(16'd1, 16'd1, 16'd1);
        run_phase(495, 0);
        drain();
        write_config(16'hffff, 16'hffff, 16'hffff);
        run_phase(495, 30);
        drain();
        write_config(16'd2, 16'd0, 16'($urandom_range(2, 40)));
        run_phase(495, 5);
        drain();
        repeat (5) @(posedge clk);

        if (fail_count == 0)
            $display("** millisecond_housekeeping_timer_unit: PASSED **");
        else
            $display("** millisecond_housekeeping_timer_unit: FAILED **");
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("** millisecond_housekeeping_timer_unit: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
design/mhtu_pkg.sv
design/millisecond_housekeeping_timer_unit.sv
tb/mhtu_tick_checker.sv
tb/tb_top.sv
